FILE: rtl/flanger_interpolated_delay_unit_macros.svh
`ifndef FLANGER_INTERPOLATED_DELAY_UNIT_MACROS_SVH
`define FLANGER_INTERPOLATED_DELAY_UNIT_MACROS_SVH

// Checked only out of reset.
`define FIDU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FIDU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fidu_pkg.sv
package fidu_pkg;

	localparam int DELAY_DEPTH     = 128;
	localparam int DLY_AW          = $clog2(DELAY_DEPTH);
	localparam int COS_TABLE_DEPTH = 256;
	localparam int COS_IW          = $clog2(COS_TABLE_DEPTH);

	localparam int SAMPLE_W   = 8;
	localparam int GAIN_W     = 16;
	localparam int MAXD_W     = 7;
	localparam int PHASE_W    = 32;
	localparam int FRAC_W     = 14;
	localparam int COS_W      = FRAC_W + 1;
	localparam int DELAY_W    = MAXD_W + COS_W;
	localparam int TAP_W      = DELAY_W - FRAC_W;
	localparam int V_W        = SAMPLE_W + FRAC_W + 1;
	localparam int SCALED_W   = V_W + GAIN_W;
	localparam int TOT_W      = SCALED_W + 1;
	localparam int OUT_SHIFT  = 2 * FRAC_W;
	localparam int QSH_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// divide by five: (n * 205) >> 10 is exact for n below 1024
	localparam int RECIP5      = 205;
	localparam int RECIP5_W    = 8;
	localparam int RECIP5_SH   = 10;

	localparam logic signed [GAIN_W-1:0] GAIN_RST      = 16'sd13107;
	localparam logic [MAXD_W-1:0]        MAX_DELAY_RST = 7'd90;
	localparam logic [PHASE_W-1:0]       STEP_RST      = 32'd973916;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN       = 2'd0,
		CFG_MAX_DELAY  = 2'd1,
		CFG_PHASE_STEP = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDA,
		ST_RDB,
		ST_MIX,
		ST_SCALE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_a;
		logic rd_b;
		logic mix;
		logic scale;
		logic fin;
	} cmd_t;

	// |cos| table, Q1.14, built at elaboration from a truncated Taylor series in Q30
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint Q14_ONE = 64'sd16384;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam longint TAYLOR_DIV [6] = '{132, 90, 56, 30, 12, 2};

	typedef logic [COS_TABLE_DEPTH-1:0][COS_W-1:0] cos_rom_t;

	function automatic logic [COS_W-1:0] abs_cos_q14(int unsigned k);
		logic [63:0]        d;
		logic [63:0]        mm;
		logic [63:0]        n;
		logic [63:0]        theta;
		logic [63:0]        x2;
		logic signed [63:0] t;
		logic signed [63:0] term;
		int                 i;
		d = 64'(COS_TABLE_DEPTH);
		mm = (64'(k) * 64'd2) % 64'(COS_TABLE_DEPTH);
		n = (mm < d - mm) ? mm : d - mm;
		theta = (PI_Q30 * n) / 64'(COS_TABLE_DEPTH);
		x2 = (theta * theta) >> 30;
		t = Q30_ONE;
		for (i = 0; i < 6; i++) begin
			term = signed'((x2 * unsigned'(t)) >> 30);
			t = Q30_ONE - term / TAYLOR_DIV[i];
			if (t < 0) begin
				t = 0;
			end
		end
		t = (t + 64'sd32768) >>> 16;
		if (t > Q14_ONE) begin
			t = Q14_ONE;
		end
		return t[COS_W-1:0];
	endfunction

	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		int       k;
		for (k = 0; k < COS_TABLE_DEPTH; k++) begin
			rom[k] = abs_cos_q14(k);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

FILE: rtl/flanger_interpolated_delay_unit.sv
// Flanger: each accepted 8-bit sample yields one flanged 8-bit sample, in order.
// The accepting cycle looks up |cos| and forms the delay; the result register is
// loaded at the end of these steps, in order: two reads through the delay store's single
// read port (the two neighboring taps), one interpolation multiply, one gain
// multiply, and one to divide by five, saturate and store the sample. A new
// sample can be taken in the cycle after the previous result is registered. If
// the previous result is still held at the output when a sample reaches its last
// step, that sample waits there until the output is taken.
// The delay store reads as zero after reset through per-entry valid bits, so
// there is no clearing pass. Configuration writes are always taken (cfg_ready
// stays high) and should only be made while no sample is in flight.
module flanger_interpolated_delay_unit import fidu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	fidu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fidu_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule

FILE: rtl/fidu_ctrl.sv
`include "flanger_interpolated_delay_unit_macros.svh"

module fidu_ctrl import fidu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_RDA;
			ST_RDA:   state_nxt = ST_RDB;
			ST_RDB:   state_nxt = ST_MIX;
			ST_MIX:   state_nxt = ST_SCALE;
			ST_SCALE: state_nxt = ST_FIN;
			ST_FIN:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.load  = in_valid;
			ST_RDA:   cmd.rd_a  = 1'b1;
			ST_RDB:   cmd.rd_b  = 1'b1;
			ST_MIX:   cmd.mix   = 1'b1;
			ST_SCALE: cmd.scale = 1'b1;
			ST_FIN:   cmd.fin   = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a finished result replaces the one being taken in the same cycle
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`FIDU_ASSERT(a_accept_starts_read, (in_valid && !in_stall) |=> (state_q == ST_RDA), "accepted transaction did not start tap reads")
	`FIDU_ASSERT(a_fin_shows_result, cmd.fin |=> out_valid, "finished sample not presented")
	`FIDU_ASSERT(a_held_result_blocks_fin, (out_valid && out_stall) |-> !cmd.fin, "pending result overwritten")
	`FIDU_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.load, cmd.rd_a, cmd.rd_b, cmd.mix, cmd.scale, cmd.fin}), "datapath commands overlap")

endmodule

FILE: rtl/fidu_datapath.sv
module fidu_datapath import fidu_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [SAMPLE_W-1:0]   sample_in,
	output logic signed [SAMPLE_W-1:0]   sample_out
);

	// configuration
	logic signed [GAIN_W-1:0] gain_q;
	logic [MAXD_W-1:0]        max_delay_q;
	logic [PHASE_W-1:0]       step_q;

	// sample state
	logic [PHASE_W-1:0]       phase_q;
	logic [DLY_AW-1:0]        wp_q;
	logic [DELAY_DEPTH-1:0]   valid_q;
	logic [SAMPLE_W-1:0]      mem [DELAY_DEPTH];
	logic [SAMPLE_W-1:0]      rd_q;
	logic                     rdv_q;

	// per-sample pipeline registers
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [TAP_W-1:0]           m_s1;
	logic [FRAC_W-1:0]          p_s1;
	logic signed [SAMPLE_W-1:0] a_s2;
	logic signed [V_W-1:0]      v_s3;
	logic signed [TOT_W-1:0]    total_s4;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic [COS_IW-1:0]          cos_idx;
	logic [COS_W-1:0]           cos_val;
	logic [DELAY_W-1:0]         delay;
	logic [DLY_AW-1:0]          idx_a;
	logic [DLY_AW-1:0]          idx_b;
	logic [DLY_AW-1:0]          rd_addr;
	logic signed [SAMPLE_W-1:0] tap_rd;
	logic signed [SAMPLE_W-1:0] a_val;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [FRAC_W:0]     p_sgn;
	logic signed [SAMPLE_W+FRAC_W+1:0] prod;
	logic signed [V_W-1:0]      v_nxt;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [TOT_W-1:0]    total_nxt;
	logic                       neg;
	logic [TOT_W-1:0]           mag;
	logic [QSH_W-1:0]           q_sh;
	logic [QSH_W+RECIP5_W-1:0]  q_full;
	logic [SAMPLE_W-1:0]        q_mag;
	logic signed [SAMPLE_W:0]   q_sgn;
	logic signed [SAMPLE_W-1:0] q_sat;

	function automatic logic [DLY_AW-1:0] tap_index(logic [DLY_AW-1:0] wp,
			logic [TAP_W:0] tap_dist);
		logic [DLY_AW:0] dc;
		dc = (int'(tap_dist) > DELAY_DEPTH) ? (DLY_AW+1)'(DELAY_DEPTH) :
			(DLY_AW+1)'(tap_dist);
		return wp - dc[DLY_AW-1:0];
	endfunction

	assign cos_idx = phase_q[PHASE_W-1 -: COS_IW];
	assign cos_val = COS_ROM[cos_idx];
	assign delay   = max_delay_q * cos_val;

	assign idx_a   = tap_index(wp_q, {1'b0, m_s1});
	assign idx_b   = tap_index(wp_q, (TAP_W+1)'(m_s1) + 1'b1);
	assign rd_addr = cmd.rd_a ? idx_a : idx_b;

	// never-written entries read as zero
	assign tap_rd = rdv_q ? signed'(rd_q) : '0;
	// tap distance zero is the current sample itself
	assign a_val  = (m_s1 == '0) ? x_s1 : tap_rd;

	// (2^14-p)*a + p*b = a*2^14 + p*(b-a)
	assign diff   = (SAMPLE_W+1)'(tap_rd) - (SAMPLE_W+1)'(a_s2);
	assign p_sgn  = signed'({1'b0, p_s1});
	assign prod   = diff * p_sgn;
	assign v_nxt  = (V_W'(a_s2) <<< FRAC_W) + V_W'(prod);

	assign scaled    = v_s3 * gain_q;
	assign total_nxt = (TOT_W'(x_s1) <<< OUT_SHIFT) + TOT_W'(scaled);

	// truncate toward zero: divide the magnitude, then restore the sign
	assign neg    = total_s4[TOT_W-1];
	assign mag    = neg ? unsigned'(-total_s4) : unsigned'(total_s4);
	assign q_sh   = mag[OUT_SHIFT +: QSH_W];
	assign q_full = q_sh * RECIP5_W'(RECIP5);
	assign q_mag  = q_full[RECIP5_SH +: SAMPLE_W];
	assign q_sgn  = neg ? -signed'({1'b0, q_mag}) : signed'({1'b0, q_mag});

	always_comb begin
		if (q_sgn > (SAMPLE_W+1)'(signed'(8'sd127))) begin
			q_sat = 8'sd127;
		end else if (q_sgn < -(SAMPLE_W+1)'(signed'(9'sd128))) begin
			q_sat = -8'sd128;
		end else begin
			q_sat = q_sgn[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_RST;
			max_delay_q <= MAX_DELAY_RST;
			step_q      <= STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN:       gain_q      <= signed'(cfg_data[GAIN_W-1:0]);
				CFG_MAX_DELAY:  max_delay_q <= cfg_data[MAXD_W-1:0];
				CFG_PHASE_STEP: step_q      <= cfg_data[PHASE_W-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wp_q    <= '0;
			valid_q <= '0;
		end else if (cmd.fin) begin
			phase_q       <= phase_q + step_q;
			wp_q          <= wp_q + 1'b1;
			valid_q[wp_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			mem[wp_q] <= x_s1;
		end
		if (cmd.rd_a || cmd.rd_b) begin
			rd_q  <= mem[rd_addr];
			rdv_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_s1 <= sample_in;
			m_s1 <= delay[DELAY_W-1:FRAC_W];
			p_s1 <= delay[FRAC_W-1:0];
		end
		if (cmd.rd_b) begin
			a_s2 <= a_val;
		end
		if (cmd.mix) begin
			v_s3 <= v_nxt;
		end
		if (cmd.scale) begin
			total_s4 <= total_nxt;
		end
		if (cmd.fin) begin
			sample_out_q <= q_sat;
		end
	end

	assign sample_out = sample_out_q;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import fidu_pkg::*;

	localparam int                     WATCHDOG_LIMIT = 3000;
	localparam int                     HOLD_CYCLES    = 400;
	localparam int                     SETTLE_CYCLES  = 8;
	localparam logic [CFG_IDX_W-1:0]   CFG_SPARE_IDX  = 2'd3;
	localparam longint                 ONE_Q30        = 64'sd1073741824;
	localparam logic [63:0]            PI_FIXED       = 64'd3373259426;
	localparam longint                 SERIES_DEN [6] = '{132, 90, 56, 30, 12, 2};
	localparam longint                 OUT_DIVISOR    = 64'sd1342177280;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in  = '0;
	logic                       out_valid;
	logic                       out_stall  = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_DATA_W-1:0]      cfg_data   = '0;

	// predictor state
	logic [COS_W-1:0]           abs_cos_tab [COS_TABLE_DEPTH];
	logic signed [SAMPLE_W-1:0] sample_hist [DELAY_DEPTH];
	int                         hist_wr;
	logic [PHASE_W-1:0]         lfo_acc;
	logic signed [GAIN_W-1:0]   cur_gain;
	logic [MAXD_W-1:0]          cur_max_delay;
	logic [PHASE_W-1:0]         cur_step;

	logic signed [SAMPLE_W-1:0] flanged_due [$];

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_tog      = 1'b0;
	logic hold_seen     = 1'b0;
	int   hold_left     = 0;
	int   quiet_cycles  = 0;
	int   err_count     = 0;
	int   n_samples     = 0;
	int   n_results     = 0;
	int   n_writes      = 0;

	flanger_interpolated_delay_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// |cos| in Q1.14 from a truncated Taylor series in Q30, rounded half up
	function automatic logic [COS_W-1:0] cos_mag_q14(input int k);
		logic [63:0] wrapped;
		logic [63:0] fold;
		logic [63:0] angle;
		logic [63:0] ang_sq;
		longint      acc;
		longint      term;
		int          i;
		wrapped = (64'(k) * 64'd2) % 64'(COS_TABLE_DEPTH);
		fold = (wrapped < 64'(COS_TABLE_DEPTH) - wrapped) ?
			wrapped : 64'(COS_TABLE_DEPTH) - wrapped;
		angle = (PI_FIXED * fold) / 64'(COS_TABLE_DEPTH);
		ang_sq = (angle * angle) >> 30;
		acc = ONE_Q30;
		for (i = 0; i < 6; i++) begin
			term = longint'((ang_sq * 64'(acc)) >> 30);
			acc = ONE_Q30 - term / SERIES_DEN[i];
			if (acc < 0) begin
				acc = 0;
			end
		end
		acc = (acc + 64'sd32768) >>> 16;
		if (acc > 64'sd16384) begin
			acc = 64'sd16384;
		end
		return acc[COS_W-1:0];
	endfunction

	function automatic longint delayed_sample(input int tap_dist,
			input logic signed [SAMPLE_W-1:0] x);
		if (tap_dist == 0) begin
			return longint'(x);
		end
		if (tap_dist > DELAY_DEPTH) begin
			tap_dist = DELAY_DEPTH;
		end
		return longint'(sample_hist[(hist_wr + DELAY_DEPTH - tap_dist) % DELAY_DEPTH]);
	endfunction

	// Work out the flanged output for x, then advance the history and the LFO.
	function automatic logic signed [SAMPLE_W-1:0] flange_sample(
			input logic signed [SAMPLE_W-1:0] x);
		logic [COS_W-1:0]   cmag;
		logic [DELAY_W-1:0] dly;
		int                 tap_m;
		longint             frac;
		longint             interp;
		longint             mixsum;
		longint             quo;
		cmag = abs_cos_tab[lfo_acc[PHASE_W-1 -: COS_IW]];
		dly = DELAY_W'(cur_max_delay) * DELAY_W'(cmag);
		tap_m = int'(dly >> FRAC_W);
		frac = longint'(dly[FRAC_W-1:0]);
		interp = (64'sd16384 - frac) * delayed_sample(tap_m, x)
			+ frac * delayed_sample(tap_m + 1, x);
		mixsum = longint'(x) * 64'sd268435456 + interp * longint'(cur_gain);
		quo = mixsum / OUT_DIVISOR;
		if (quo > 127) begin
			quo = 127;
		end
		if (quo < -128) begin
			quo = -128;
		end
		sample_hist[hist_wr] = x;
		hist_wr = (hist_wr + 1) % DELAY_DEPTH;
		lfo_acc = lfo_acc + cur_step;
		return quo[SAMPLE_W-1:0];
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (in_stall);
		flanged_due.push_back(flange_sample(x));
		n_samples++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_GAIN:       cur_gain      = val[GAIN_W-1:0];
			CFG_MAX_DELAY:  cur_max_delay = val[MAXD_W-1:0];
			CFG_PHASE_STEP: cur_step      = val;
			default:        ;
		endcase
		n_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, wait for every result, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (flanged_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0:       return 8'sh7f;
			1:       return 8'sh80;
			2:       return 8'sh00;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic pick_settings();
		logic [CFG_DATA_W-1:0] gain_word;
		logic [CFG_DATA_W-1:0] md_word;
		logic [CFG_DATA_W-1:0] step_word;
		gain_word = $urandom;
		md_word = $urandom;
		step_word = $urandom;
		case ($urandom_range(3))
			0:       gain_word[GAIN_W-1:0] = 16'h7fff;
			1:       gain_word[GAIN_W-1:0] = 16'h8000;
			default: ;
		endcase
		case ($urandom_range(5))
			0:       md_word[MAXD_W-1:0] = 7'd0;
			1:       md_word[MAXD_W-1:0] = 7'd1;
			2:       md_word[MAXD_W-1:0] = 7'd126;
			3:       md_word[MAXD_W-1:0] = 7'd127;
			default: ;
		endcase
		case ($urandom_range(4))
			0:       step_word = 32'hffff_ffff;
			1:       step_word = $urandom_range(32'h0010_0000);
			2:       step_word = 32'h0100_0000 * $urandom_range(1, 8);
			default: ;
		endcase
		write_reg(CFG_GAIN, gain_word);
		write_reg(CFG_MAX_DELAY, md_word);
		write_reg(CFG_PHASE_STEP, step_word);
		if ($urandom_range(3) == 0) begin
			write_reg(CFG_SPARE_IDX, $urandom);
		end
	endtask

	// Reset values, with the history still all zeros.
	task automatic test_startup_defaults();
		logic signed [SAMPLE_W-1:0] vals [8] = '{127, -128, 0, -1, 1, 85, -86, 64};
		int i;
		for (i = 0; i < 8; i++) begin
			send_sample(vals[i]);
		end
	endtask

	task automatic test_extremes();
		int i;
		drain();
		// no delay at all: output is (x + gain*x)/5
		write_reg(CFG_GAIN, 32'h0000_7fff);
		write_reg(CFG_MAX_DELAY, 32'h0000_0000);
		write_reg(CFG_PHASE_STEP, 32'h0000_0000);
		send_sample(8'sh7f);
		send_sample(8'sh80);
		send_sample(8'shff);
		drain();
		write_reg(CFG_GAIN, 32'hffff_8000);
		write_reg(CFG_SPARE_IDX, 32'h5a5a_a5a5);
		send_sample(8'sh7f);
		send_sample(8'sh80);
		drain();
		// one-sample peak delay: the tap mostly lands on the current sample
		write_reg(CFG_MAX_DELAY, 32'hffff_ff81);
		write_reg(CFG_PHASE_STEP, 32'h2000_0000);
		for (i = 0; i < 6; i++) begin
			send_sample(rand_sample());
		end
		drain();
		// full depth: the far tap reaches the deepest entry of the delay store
		write_reg(CFG_GAIN, 32'h0000_4000);
		write_reg(CFG_MAX_DELAY, 32'h0000_007f);
		write_reg(CFG_PHASE_STEP, 32'h0100_0000);
		for (i = 0; i < 5; i++) begin
			send_sample(rand_sample());
		end
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
		int seg;
		int i;
		for (seg = 0; seg < 3; seg++) begin
			drain();
			send_idle_pct = snd_pct;
			recv_idle_pct = rcv_pct;
			pick_settings();
			for (i = 0; i < 40; i++) begin
				send_sample(rand_sample());
			end
		end
	endtask

	// Hold the output for a long stretch while samples keep coming.
	task automatic test_output_holdoff();
		int i;
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_tog <= ~hold_tog;
		for (i = 0; i < 20; i++) begin
			send_sample(rand_sample());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (flanged_due.size() == 0) begin
				$display("%0t: unexpected sample_out transaction, expected none, got %0d",
					$time, sample_out);
				err_count++;
			end else begin
				if (sample_out !== flanged_due[0]) begin
					$display("%0t: sample_out mismatch, expected %0d, got %0d",
						$time, flanged_due[0], sample_out);
					err_count++;
				end
				void'(flanged_due.pop_front());
			end
		end
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
			abs_cos_tab[k] = cos_mag_q14(k);
		end
		for (int k = 0; k < DELAY_DEPTH; k++) begin
			sample_hist[k] = '0;
		end
		hist_wr = 0;
		lfo_acc = '0;
		cur_gain = GAIN_RST;
		cur_max_delay = MAX_DELAY_RST;
		cur_step = STEP_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup_defaults();
		test_extremes();
		test_random_traffic(13, 67);
		test_random_traffic(67, 13);
		test_random_traffic(0, 0);
		test_output_holdoff();
		drain();
		repeat (20) @(posedge clk);

		$display("summary: %0d samples in, %0d results checked, %0d register writes",
			n_samples, n_results, n_writes);
		$display("summary: gain and delay extremes, zero delay, full-depth taps, %s",
			"three idle mixes and a long output hold-off");
		if (err_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
